>>> hw/rtl/bwpc_pkg.sv
// Shared types and constants for the baseline and windowed peak capture block.
package bwpc_pkg;

    // Fixed field widths
    localparam int SAMPLE_W   = 12;
    localparam int TS_W       = 32;
    localparam int COUNT_W    = 20;
    localparam int SUM_W      = 32;
    localparam int NUM_WIN_W  = 11;
    localparam int WIN_LEN_W  = 16;
    localparam int WAIT_W     = 20;
    localparam int MARGIN_W   = 12;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int QUOT_W     = 12;
    localparam int DIV_CNT_W  = $clog2(QUOT_W + 1);

    // Command codes
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_WINDOWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_WAIT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_MARGIN  = 2'd3;

    // Register reset values
    localparam logic [NUM_WIN_W-1:0] NUM_WINDOWS_RST = 11'd700;
    localparam logic [WIN_LEN_W-1:0] WINDOW_LEN_RST  = 16'd50;
    localparam logic [WAIT_W-1:0]    BASE_WAIT_RST   = 20'd15000;
    localparam logic [MARGIN_W-1:0]  BASE_MARGIN_RST = 12'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BASE,
        ST_DIV,
        ST_WIN
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;        // open a new capture
        logic accum;        // add sample to baseline sum
        logic div_start;    // load divider, hold closing sample
        logic div_step;     // one quotient bit
        logic div_finish;   // store baseline, open first window
        logic win_sample;   // raise window peak
        logic emit;         // close window, load output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic base_open;    // sample falls inside baseline wait
        logic count_full;
        logic limit_zero;
        logic div_done;
        logic win_expired;
        logic last;
        logic out_stall;    // output register full and not taken
    } dp_status_t;

endpackage

>>> hw/rtl/bwpc_in_if.sv
// Input item channel: command, sample and timestamp.
interface bwpc_in_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [bwpc_pkg::SAMPLE_W-1:0] sample_value;
    logic [bwpc_pkg::TS_W-1:0]     timestamp_us;

    modport source (output valid, command, sample_value, timestamp_us, input ready);
    modport sink   (input valid, command, sample_value, timestamp_us, output ready);
endinterface

>>> hw/rtl/bwpc_out_if.sv
// Result item channel: one window result per item.
interface bwpc_out_if;
    logic                          valid;
    logic                          ready;
    logic [bwpc_pkg::TS_W-1:0]     window_offset_us;
    logic [bwpc_pkg::SAMPLE_W-1:0] peak_value;
    logic [bwpc_pkg::SAMPLE_W-1:0] baseline_value;
    logic                          last_window;

    modport source (output valid, window_offset_us, peak_value, baseline_value, last_window,
                    input ready);
    modport sink   (input valid, window_offset_us, peak_value, baseline_value, last_window,
                    output ready);
endinterface

>>> hw/rtl/bwpc_ctrl.sv
// Capture controller: phase state machine issuing datapath commands.
module bwpc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_command,
    input  bwpc_pkg::dp_status_t  status,
    output logic                  in_ready,
    output bwpc_pkg::dp_cmd_t     cmd
);

    bwpc_pkg::ctrl_state_t state_reg;
    bwpc_pkg::ctrl_state_t state_next;
    logic                  fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bwpc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg != bwpc_pkg::ST_DIV) && !status.out_stall;
        fire       = in_valid && in_ready;

        case (state_reg)
            bwpc_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.div_finish = 1'b1;
                    state_next     = bwpc_pkg::ST_WIN;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            default:
            begin
                if (fire)
                begin
                    if (in_command == bwpc_pkg::CMD_START)
                    begin
                        cmd.start  = 1'b1;
                        state_next = bwpc_pkg::ST_BASE;
                    end
                    else
                    begin
                        case (state_reg)
                            bwpc_pkg::ST_BASE:
                            begin
                                if (status.base_open)
                                begin
                                    cmd.accum = !status.count_full;
                                end
                                else if (status.limit_zero)
                                begin
                                    state_next = bwpc_pkg::ST_IDLE;
                                end
                                else
                                begin
                                    cmd.div_start = 1'b1;
                                    state_next    = bwpc_pkg::ST_DIV;
                                end
                            end
                            bwpc_pkg::ST_WIN:
                            begin
                                if (!status.win_expired)
                                begin
                                    cmd.win_sample = 1'b1;
                                end
                                else
                                begin
                                    cmd.emit = 1'b1;
                                    if (status.last)
                                    begin
                                        state_next = bwpc_pkg::ST_IDLE;
                                    end
                                end
                            end
                            default:
                            begin
                                // samples while idle are dropped
                            end
                        endcase
                    end
                end
            end
        endcase
    end

endmodule

>>> hw/rtl/bwpc_datapath.sv
// Capture datapath: config registers, baseline sum, divider, window peak, output register.
module bwpc_datapath #(
    parameter int MAX_WINDOWS = 1024,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bwpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bwpc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [bwpc_pkg::SAMPLE_W-1:0]    sample_value,
    input  logic [bwpc_pkg::TS_W-1:0]        timestamp_us,
    input  logic                             out_ready,
    input  bwpc_pkg::dp_cmd_t                cmd,
    output bwpc_pkg::dp_status_t             status,
    output logic                             out_valid,
    output logic [bwpc_pkg::TS_W-1:0]        window_offset_us,
    output logic [bwpc_pkg::SAMPLE_W-1:0]    peak_value,
    output logic [bwpc_pkg::SAMPLE_W-1:0]    baseline_value,
    output logic                             last_window
);

    localparam int WD_W = $clog2(MAX_WINDOWS + 1);
    localparam logic [bwpc_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
        (SAMPLE_BITS >= bwpc_pkg::SAMPLE_W) ? {bwpc_pkg::SAMPLE_W{1'b1}}
        : bwpc_pkg::SAMPLE_W'((32'd1 << SAMPLE_BITS) - 32'd1);

    // config
    logic [bwpc_pkg::NUM_WIN_W-1:0] num_windows_reg;
    logic [bwpc_pkg::WIN_LEN_W-1:0] window_len_reg;
    logic [bwpc_pkg::WAIT_W-1:0]    base_wait_reg;
    logic [bwpc_pkg::MARGIN_W-1:0]  base_margin_reg;

    // capture state
    logic [bwpc_pkg::TS_W-1:0]     phase_start_reg;
    logic [bwpc_pkg::SUM_W-1:0]    base_sum_reg;
    logic [bwpc_pkg::COUNT_W-1:0]  base_count_reg;
    logic [bwpc_pkg::SAMPLE_W-1:0] baseline_reg;
    logic [bwpc_pkg::TS_W-1:0]     win_start_reg;
    logic [bwpc_pkg::SAMPLE_W-1:0] win_peak_reg;
    logic [WD_W-1:0]               windows_done_reg;

    // divider
    logic [bwpc_pkg::SUM_W-1:0]     rem_reg;
    logic [bwpc_pkg::SUM_W-1:0]     dvs_reg;
    logic [bwpc_pkg::QUOT_W-1:0]    quot_reg;
    logic [bwpc_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic [bwpc_pkg::TS_W-1:0]      hold_time_reg;
    logic [bwpc_pkg::SAMPLE_W-1:0]  hold_sample_reg;

    logic                          out_valid_reg;
    logic [bwpc_pkg::TS_W-1:0]     out_offset_reg;
    logic [bwpc_pkg::SAMPLE_W-1:0] out_peak_reg;
    logic [bwpc_pkg::SAMPLE_W-1:0] out_base_reg;
    logic                          out_last_reg;

    logic [bwpc_pkg::SAMPLE_W-1:0]  v;
    logic [bwpc_pkg::WIN_LEN_W-1:0] win_len;
    logic [WD_W-1:0]                win_limit;
    logic [bwpc_pkg::SAMPLE_W-1:0]  new_baseline;
    logic [bwpc_pkg::SAMPLE_W-1:0]  seed_new;
    logic [bwpc_pkg::SAMPLE_W-1:0]  seed_cur;
    logic [bwpc_pkg::SAMPLE_W-1:0]  first_peak;
    logic [bwpc_pkg::SAMPLE_W-1:0]  next_peak;
    logic                           rem_ge;

    assign v       = sample_value & SAMPLE_MASK;
    assign win_len = (window_len_reg == '0) ? bwpc_pkg::WIN_LEN_W'(1) : window_len_reg;
    assign win_limit = (32'(num_windows_reg) > 32'(MAX_WINDOWS)) ? WD_W'(MAX_WINDOWS)
                                                                 : WD_W'(num_windows_reg);

    assign new_baseline = (base_count_reg == '0) ? '0 : (quot_reg & SAMPLE_MASK);
    assign seed_new   = (new_baseline > base_margin_reg) ? new_baseline - base_margin_reg : '0;
    assign seed_cur   = (baseline_reg > base_margin_reg) ? baseline_reg - base_margin_reg : '0;
    assign first_peak = (hold_sample_reg > seed_new) ? hold_sample_reg : seed_new;
    assign next_peak  = (v > seed_cur) ? v : seed_cur;
    assign rem_ge     = rem_reg >= dvs_reg;

    always_comb
    begin
        status.base_open   = (timestamp_us - phase_start_reg) < 32'(base_wait_reg);
        status.count_full  = (base_count_reg == {bwpc_pkg::COUNT_W{1'b1}});
        status.limit_zero  = (win_limit == '0);
        status.div_done    = (div_cnt_reg == '0);
        status.win_expired = (timestamp_us - win_start_reg) >= 32'(win_len);
        status.last        = ({1'b0, windows_done_reg} + (WD_W + 1)'(1)) >= {1'b0, win_limit};
        status.out_stall   = out_valid_reg && !out_ready;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_windows_reg  <= bwpc_pkg::NUM_WINDOWS_RST;
            window_len_reg   <= bwpc_pkg::WINDOW_LEN_RST;
            base_wait_reg    <= bwpc_pkg::BASE_WAIT_RST;
            base_margin_reg  <= bwpc_pkg::BASE_MARGIN_RST;
            out_valid_reg    <= 1'b0;
            div_cnt_reg      <= '0;
            windows_done_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bwpc_pkg::REG_NUM_WINDOWS:
                        num_windows_reg <= cfg_data[bwpc_pkg::NUM_WIN_W-1:0];
                    bwpc_pkg::REG_WINDOW_LEN:
                        window_len_reg <= cfg_data[bwpc_pkg::WIN_LEN_W-1:0];
                    bwpc_pkg::REG_BASE_WAIT:
                        base_wait_reg <= cfg_data[bwpc_pkg::WAIT_W-1:0];
                    bwpc_pkg::REG_BASE_MARGIN:
                        base_margin_reg <= cfg_data[bwpc_pkg::MARGIN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.div_start)
            begin
                div_cnt_reg <= bwpc_pkg::DIV_CNT_W'(bwpc_pkg::QUOT_W);
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg - bwpc_pkg::DIV_CNT_W'(1);
            end

            if (cmd.start || cmd.div_start)
            begin
                windows_done_reg <= '0;
            end
            else if (cmd.emit)
            begin
                windows_done_reg <= windows_done_reg + WD_W'(1);
            end
        end
    end

    // data path
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            phase_start_reg <= timestamp_us;
            base_sum_reg    <= '0;
            base_count_reg  <= '0;
            baseline_reg    <= '0;
            win_start_reg   <= '0;
            win_peak_reg    <= '0;
        end
        if (cmd.accum)
        begin
            base_sum_reg   <= base_sum_reg + bwpc_pkg::SUM_W'(v);
            base_count_reg <= base_count_reg + bwpc_pkg::COUNT_W'(1);
        end
        if (cmd.div_start)
        begin
            // restoring division; quotient never exceeds the sample range
            rem_reg         <= base_sum_reg;
            dvs_reg         <= bwpc_pkg::SUM_W'(base_count_reg) << (bwpc_pkg::QUOT_W - 1);
            quot_reg        <= '0;
            hold_time_reg   <= timestamp_us;
            hold_sample_reg <= v;
        end
        if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_reg - dvs_reg;
            end
            quot_reg <= {quot_reg[bwpc_pkg::QUOT_W-2:0], rem_ge};
            dvs_reg  <= dvs_reg >> 1;
        end
        if (cmd.div_finish)
        begin
            baseline_reg    <= new_baseline;
            phase_start_reg <= hold_time_reg;
            win_start_reg   <= hold_time_reg;
            win_peak_reg    <= first_peak;
        end
        if (cmd.win_sample && (v > win_peak_reg))
        begin
            win_peak_reg <= v;
        end
        if (cmd.emit)
        begin
            out_offset_reg <= win_start_reg - phase_start_reg;
            out_peak_reg   <= win_peak_reg;
            out_base_reg   <= baseline_reg;
            out_last_reg   <= status.last;
            // closing sample opens the next window
            win_start_reg  <= timestamp_us;
            win_peak_reg   <= next_peak;
        end
    end

    assign out_valid        = out_valid_reg;
    assign window_offset_us = out_offset_reg;
    assign peak_value       = out_peak_reg;
    assign baseline_value   = out_base_reg;
    assign last_window      = out_last_reg;

endmodule

>>> hw/rtl/baseline_and_windowed_peak_capture.sv
// Top level: baseline averaging and windowed peak capture over a sample stream.
//
// sample_in carries items of command (start or sample), a 12-bit reading and a
// microsecond timestamp. A start item opens a capture; samples within the baseline
// wait are averaged, the first later sample fixes the baseline and opens the first
// window. Each window closed by a later sample yields one result_out item with the
// window offset, its peak, the baseline and a flag on the final window.
// Throughput: one input item per cycle while sample_in is ready. The sample that ends
// the baseline phase is taken, then sample_in is not ready while the restoring
// divider (one quotient bit per cycle, 12 bits) forms sum / count.
// A result is in the output register in the cycle after its closing sample.
// The output register is single entry: while it holds an untaken result, sample_in
// is not ready; it is ready again in the cycle the result is taken.
// Configuration writes (cfg_we, cfg_index, cfg_data) land at the next edge and are
// meant for idle periods. Reset loads the register defaults, empties the output
// register and leaves the block idle, ignoring samples until a start.
module baseline_and_windowed_peak_capture #(
    parameter int MAX_WINDOWS = 1024,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    bwpc_in_if.sink                          sample_in,
    bwpc_out_if.source                       result_out,
    input  logic                             cfg_we,
    input  logic [bwpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bwpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    bwpc_pkg::dp_cmd_t    cmd;
    bwpc_pkg::dp_status_t status;

    // phase sequencing and handshake
    bwpc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sample_in.valid),
        .in_command (sample_in.command),
        .status     (status),
        .in_ready   (sample_in.ready),
        .cmd        (cmd)
    );

    // arithmetic, timing compares and result register
    bwpc_datapath #(
        .MAX_WINDOWS (MAX_WINDOWS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .sample_value     (sample_in.sample_value),
        .timestamp_us     (sample_in.timestamp_us),
        .out_ready        (result_out.ready),
        .cmd              (cmd),
        .status           (status),
        .out_valid        (result_out.valid),
        .window_offset_us (result_out.window_offset_us),
        .peak_value       (result_out.peak_value),
        .baseline_value   (result_out.baseline_value),
        .last_window      (result_out.last_window)
    );

endmodule
